>>> hdl/eib_pkg.sv
// ----------------------------------------------------------------------------
// eib_pkg
// Types and constants shared by the encoder/switch to bus target bridge.
// ----------------------------------------------------------------------------
package eib_pkg;

	localparam int RX_DEPTH = 5;
	localparam int WC_W     = $clog2(RX_DEPTH + 1);

	localparam int Q_DEPTH  = 4;
	localparam int Q_AW     = $clog2(Q_DEPTH);
	localparam int Q_CW     = $clog2(Q_DEPTH + 1);

	localparam int ADDR_W   = 4;

	localparam logic [15:0] DEBOUNCE_RST = 16'd50;
	localparam logic [15:0] TIMEOUT_RST  = 16'd1000;
	localparam logic [7:0]  STATUS_RST   = 8'h08;
	localparam logic [7:0]  READ_ALL_ONES = 8'hFF;

	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_STATUS   = 2'd2;

	typedef enum logic [2:0] {
		ACT_TICK   = 3'd0,
		ACT_SAMPLE = 3'd1,
		ACT_SWITCH = 3'd2,
		ACT_WRITE  = 3'd3,
		ACT_STOP   = 3'd4,
		ACT_READ   = 3'd5
	} action_t;

	typedef struct packed {
		logic       irq_pin;
		logic       is_read;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} res_desc_t;

	localparam int DESC_W = $bits(res_desc_t);

endpackage

>>> hdl/eib_front.sv
// ----------------------------------------------------------------------------
// eib_front
// Configuration registers, event decode and bridge state; one descriptor per item.
// ----------------------------------------------------------------------------
module eib_front
	import eib_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	input  logic              accept,
	input  logic [2:0]        action,
	input  logic [15:0]       count_value,
	input  logic [7:0]        data_byte,
	output res_desc_t         desc
);

	logic [15:0] debounce_ms_q;
	logic [15:0] irq_timeout_ms_q;
	logic [7:0]  status_register_q;

	logic [31:0]     ms_counter_q, ms_counter_d;
	logic [31:0]     last_switch_q, last_switch_d;
	logic [15:0]     encoder_q, encoder_d;
	logic            switch_pend_q, switch_pend_d;
	logic            irq_raised_q, irq_raised_d;
	logic            pin_q, pin_d;
	logic [15:0]     timeout_left_q, timeout_left_d;
	logic [7:0]      sel_reg_q, sel_reg_d;
	logic [7:0]      first_wr_q, first_wr_d;
	logic [WC_W-1:0] wr_count_q, wr_count_d;

	logic        cfg_wr;
	logic [31:0] since_edge;
	logic        raise;
	logic        status_hit;

	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q     <= DEBOUNCE_RST;
			irq_timeout_ms_q  <= TIMEOUT_RST;
			status_register_q <= STATUS_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_DEBOUNCE: debounce_ms_q     <= pwdata[15:0];
				REG_TIMEOUT:  irq_timeout_ms_q  <= pwdata[15:0];
				REG_STATUS:   status_register_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DEBOUNCE: prdata = {16'd0, debounce_ms_q};
			REG_TIMEOUT:  prdata = {16'd0, irq_timeout_ms_q};
			REG_STATUS:   prdata = {24'd0, status_register_q};
			default:      prdata = 32'd0;
		endcase
	end

	assign since_edge = ms_counter_q - last_switch_q;
	assign status_hit = (sel_reg_q == status_register_q);

	always_comb begin
		ms_counter_d   = ms_counter_q;
		last_switch_d  = last_switch_q;
		encoder_d      = encoder_q;
		switch_pend_d  = switch_pend_q;
		irq_raised_d   = irq_raised_q;
		pin_d          = pin_q;
		timeout_left_d = timeout_left_q;
		sel_reg_d      = sel_reg_q;
		first_wr_d     = first_wr_q;
		wr_count_d     = wr_count_q;
		raise          = 1'b0;
		desc.is_read   = 1'b0;
		desc.b0        = 8'd0;
		desc.b1        = 8'd0;
		desc.b2        = 8'd0;

		case (action_t'(action))
			ACT_TICK: begin
				ms_counter_d = ms_counter_q + 32'd1;
				if (timeout_left_q != 16'd0) begin
					timeout_left_d = timeout_left_q - 16'd1;
					if (timeout_left_q == 16'd1)
						pin_d = 1'b0;
				end
			end
			ACT_SAMPLE: begin
				if (count_value != encoder_q) begin
					encoder_d = count_value;
					raise     = 1'b1;
				end
			end
			ACT_SWITCH: begin
				if (since_edge > {16'd0, debounce_ms_q}) begin
					last_switch_d = ms_counter_q;
					switch_pend_d = 1'b1;
					raise         = 1'b1;
				end
			end
			ACT_WRITE: begin
				if (wr_count_q == '0)
					first_wr_d = data_byte;
				if (wr_count_q < WC_W'(RX_DEPTH))
					wr_count_d = wr_count_q + 1'b1;
			end
			ACT_STOP: begin
				if (wr_count_q == WC_W'(1))
					sel_reg_d = first_wr_q;
				first_wr_d = 8'd0;
				wr_count_d = '0;
			end
			ACT_READ: begin
				desc.is_read = 1'b1;
				if (status_hit) begin
					desc.b0 = encoder_q[15:8];
					desc.b1 = encoder_q[7:0];
					desc.b2 = {7'd0, switch_pend_q};
				end else begin
					desc.b0 = READ_ALL_ONES;
					desc.b1 = READ_ALL_ONES;
					desc.b2 = READ_ALL_ONES;
				end
				irq_raised_d   = 1'b0;
				pin_d          = 1'b0;
				timeout_left_d = 16'd0;
				sel_reg_d      = 8'd0;
				switch_pend_d  = 1'b0;
			end
			default: ;
		endcase

		if (raise && !irq_raised_q) begin
			irq_raised_d   = 1'b1;
			pin_d          = 1'b1;
			timeout_left_d = irq_timeout_ms_q;
		end

		desc.irq_pin = pin_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_counter_q   <= '0;
			last_switch_q  <= '0;
			encoder_q      <= '0;
			switch_pend_q  <= 1'b0;
			irq_raised_q   <= 1'b0;
			pin_q          <= 1'b0;
			timeout_left_q <= '0;
			sel_reg_q      <= '0;
			first_wr_q     <= '0;
			wr_count_q     <= '0;
		end else if (accept) begin
			ms_counter_q   <= ms_counter_d;
			last_switch_q  <= last_switch_d;
			encoder_q      <= encoder_d;
			switch_pend_q  <= switch_pend_d;
			irq_raised_q   <= irq_raised_d;
			pin_q          <= pin_d;
			timeout_left_q <= timeout_left_d;
			sel_reg_q      <= sel_reg_d;
			first_wr_q     <= first_wr_d;
			wr_count_q     <= wr_count_d;
		end
	end

endmodule

>>> hdl/eib_queue.sv
// ----------------------------------------------------------------------------
// eib_queue
// Short descriptor queue between the event decode and the result sender.
// ----------------------------------------------------------------------------
module eib_queue
	import eib_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  res_desc_t push_desc,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output res_desc_t head
);

	res_desc_t       slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;

	assign full      = (count_q == Q_CW'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

>>> hdl/eib_back.sv
// ----------------------------------------------------------------------------
// eib_back
// Result sender: expands each descriptor into one or three output items.
// ----------------------------------------------------------------------------
module eib_back
	import eib_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      have_desc,
	input  res_desc_t head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      out_pin,
	output logic [7:0] out_byte,
	output logic      out_byte_valid,
	output logic      out_last
);

	logic       valid_q;
	logic [1:0] beat_q;
	logic       pin_q;
	logic [7:0] byte_q;
	logic       bval_q;
	logic       last_q;

	logic       load;
	logic       last_beat;
	logic [7:0] beat_byte;

	assign load      = have_desc && (!valid_q || out_ready);
	assign last_beat = !head.is_read || (beat_q == 2'd2);
	assign pop       = load && last_beat;

	always_comb begin
		case (beat_q)
			2'd0:    beat_byte = head.b0;
			2'd1:    beat_byte = head.b1;
			default: beat_byte = head.b2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				beat_q  <= last_beat ? 2'd0 : beat_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pin_q  <= head.irq_pin;
			byte_q <= head.is_read ? beat_byte : 8'd0;
			bval_q <= head.is_read;
			last_q <= last_beat;
		end
	end

	assign out_valid      = valid_q;
	assign out_pin        = pin_q;
	assign out_byte       = byte_q;
	assign out_byte_valid = bval_q;
	assign out_last       = last_q;

endmodule

>>> hdl/encoder_i2c_irq_bridge_core.sv
// ----------------------------------------------------------------------------
// encoder_i2c_irq_bridge_core
// Encoder and push switch events to a bus target register view with an
// interrupt line.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+---------------------------------------
//   s_*      | in  | s_tvalid/s_tready  | tuser action; tdata count, data byte
//   m_*      | out | m_tvalid/m_tready  | tdata pin, read byte; tuser; tlast
//   apb      | in  | psel/penable       | debounce, timeout, status register
//
// One item is accepted per cycle while the four-entry descriptor queue has room.
// A read start gives three output items, on consecutive cycles while m_tready is
// high, others one. Output is registered: a result passes the queue slot, then the
// output register. Output stalls back up through the queue into s_tready only.
// Reset clears control state and loads register defaults, not queue or output data.
// ----------------------------------------------------------------------------
module encoder_i2c_irq_bridge_core
	import eib_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,   // [15:0] count_value, [23:16] data_byte
	input  logic [2:0]        s_tuser,   // [2:0] action
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // [0] irq_pin, [8:1] read_byte, [15:9] zero
	output logic              m_tuser,   // [0] byte_valid
	output logic              m_tlast
);

	res_desc_t  new_desc;
	res_desc_t  head;
	logic       q_full;
	logic       q_have;
	logic       q_pop;
	logic       accept;
	logic       out_pin;
	logic [7:0] out_byte;

	assign pready   = 1'b1;
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	eib_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.accept      (accept),
		.action      (s_tuser),
		.count_value (s_tdata[15:0]),
		.data_byte   (s_tdata[23:16]),
		.desc        (new_desc)
	);

	eib_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_desc (new_desc),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_have),
		.head      (head)
	);

	eib_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.have_desc      (q_have),
		.head           (head),
		.pop            (q_pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_pin        (out_pin),
		.out_byte       (out_byte),
		.out_byte_valid (m_tuser),
		.out_last       (m_tlast)
	);

	assign m_tdata = {7'd0, out_byte, out_pin};

endmodule
